// File: rtl/fsg_pkg.sv
// fsg_pkg: shared types, codes and tables of the four-channel sound generator.
// No dependencies; imported by every module of the block but fsg_ram.
package fsg_pkg;

   localparam int WaveBytes        = 16;
   localparam int WaveAw           = $clog2(WaveBytes);
   localparam int SeqPeriodDefault = 8192;
   localparam int QueueDepth       = 2;

   // opcode field codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // register offsets (address minus base)
   localparam logic [5:0] OFS_SWEEP  = 6'h00;
   localparam logic [5:0] OFS_LD1    = 6'h01;
   localparam logic [5:0] OFS_ENV1   = 6'h02;
   localparam logic [5:0] OFS_FLO1   = 6'h03;
   localparam logic [5:0] OFS_FHI1   = 6'h04;
   localparam logic [5:0] OFS_LD2    = 6'h06;
   localparam logic [5:0] OFS_ENV2   = 6'h07;
   localparam logic [5:0] OFS_FLO2   = 6'h08;
   localparam logic [5:0] OFS_FHI2   = 6'h09;
   localparam logic [5:0] OFS_DAC3   = 6'h0A;
   localparam logic [5:0] OFS_LEN3   = 6'h0B;
   localparam logic [5:0] OFS_LVL3   = 6'h0C;
   localparam logic [5:0] OFS_FLO3   = 6'h0D;
   localparam logic [5:0] OFS_FHI3   = 6'h0E;
   localparam logic [5:0] OFS_LEN4   = 6'h10;
   localparam logic [5:0] OFS_ENV4   = 6'h11;
   localparam logic [5:0] OFS_POLY4  = 6'h12;
   localparam logic [5:0] OFS_FHI4   = 6'h13;
   localparam logic [5:0] OFS_MVOL   = 6'h14;
   localparam logic [5:0] OFS_PAN    = 6'h15;
   localparam logic [5:0] OFS_POWER  = 6'h16;
   localparam logic [1:0] OFS_WAVE_HI = 2'b10;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] reg_offset;
      logic [7:0] write_byte;
      logic [5:0] tick_cycles;
   } req_type;

   typedef struct packed {
      logic [7:0]         read_byte;
      logic signed [11:0] left_level;
      logic signed [11:0] right_level;
      logic [3:0]         channel_active;
   } rsp_type;

   typedef enum logic [1:0] {CMD_TICK, CMD_WRITE, CMD_READ, CMD_NOP} cmd_kind_type;

   typedef enum logic [4:0] {
      R_SWEEP, R_LD1, R_ENV1, R_FLO1, R_FHI1, R_LD2, R_ENV2, R_FLO2, R_FHI2,
      R_DAC3, R_LEN3, R_LVL3, R_FLO3, R_FHI3, R_LEN4, R_ENV4, R_POLY4, R_FHI4,
      R_MVOL, R_PAN, R_POWER, R_WAVE, R_NONE
   } reg_sel_type;

   typedef struct packed {
      cmd_kind_type kind;
      reg_sel_type  sel;
      logic [3:0]   wave_idx;
      logic [7:0]   data;
      logic [5:0]   cycles;
   } cmd_type;

   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] pat;
      case (sel)
         2'd0:    pat = 8'b1000_0000;
         2'd1:    pat = 8'b1000_0001;
         2'd2:    pat = 8'b1110_0001;
         default: pat = 8'b0111_1110;
      endcase
      return pat[pos];
   endfunction

   function automatic logic [5:0] noise_div(input logic [2:0] code);
      logic [5:0] d;
      case (code)
         3'd0:    d = 6'd4;
         3'd1:    d = 6'd8;
         3'd2:    d = 6'd16;
         3'd3:    d = 6'd24;
         3'd4:    d = 6'd32;
         3'd5:    d = 6'd40;
         3'd6:    d = 6'd48;
         default: d = 6'd56;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/fsg_ram.sv
// fsg_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
module fsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule

// File: rtl/fsg_fifo.sv
// fsg_fifo: short command queue between front decoder and back end.
// Depends on fsg_pkg (cmd_type).
module fsg_fifo import fsg_pkg::*; #(
   parameter int DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);
   localparam int Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int Cw = $clog2(DEPTH + 1);

   cmd_type        mem_ff [DEPTH];
   logic [Aw-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Cw-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full      = (count_ff == Cw'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Aw'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Aw'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// File: rtl/fsg_front.sv
// fsg_front: accepts request items, decodes opcode and register offset, queues them.
// Depends on fsg_pkg and fsg_fifo.
module fsg_front import fsg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    q_valid,
   input  logic    q_pop,
   output cmd_type q_cmd
);
   cmd_type dec_cmd;
   logic    q_full;

   always_comb begin
      dec_cmd.wave_idx = req_data.reg_offset[3:0];
      dec_cmd.data     = req_data.write_byte;
      dec_cmd.cycles   = req_data.tick_cycles;
      unique case (req_data.opcode)
         OP_TICK:  dec_cmd.kind = CMD_TICK;
         OP_WRITE: dec_cmd.kind = CMD_WRITE;
         OP_READ:  dec_cmd.kind = CMD_READ;
         default:  dec_cmd.kind = CMD_NOP;
      endcase
      unique case (req_data.reg_offset)
         OFS_SWEEP: dec_cmd.sel = R_SWEEP;
         OFS_LD1:   dec_cmd.sel = R_LD1;
         OFS_ENV1:  dec_cmd.sel = R_ENV1;
         OFS_FLO1:  dec_cmd.sel = R_FLO1;
         OFS_FHI1:  dec_cmd.sel = R_FHI1;
         OFS_LD2:   dec_cmd.sel = R_LD2;
         OFS_ENV2:  dec_cmd.sel = R_ENV2;
         OFS_FLO2:  dec_cmd.sel = R_FLO2;
         OFS_FHI2:  dec_cmd.sel = R_FHI2;
         OFS_DAC3:  dec_cmd.sel = R_DAC3;
         OFS_LEN3:  dec_cmd.sel = R_LEN3;
         OFS_LVL3:  dec_cmd.sel = R_LVL3;
         OFS_FLO3:  dec_cmd.sel = R_FLO3;
         OFS_FHI3:  dec_cmd.sel = R_FHI3;
         OFS_LEN4:  dec_cmd.sel = R_LEN4;
         OFS_ENV4:  dec_cmd.sel = R_ENV4;
         OFS_POLY4: dec_cmd.sel = R_POLY4;
         OFS_FHI4:  dec_cmd.sel = R_FHI4;
         OFS_MVOL:  dec_cmd.sel = R_MVOL;
         OFS_PAN:   dec_cmd.sel = R_PAN;
         OFS_POWER: dec_cmd.sel = R_POWER;
         default:   dec_cmd.sel = (req_data.reg_offset[5:4] == OFS_WAVE_HI) ? R_WAVE : R_NONE;
      endcase
   end

   fsg_fifo #(.DEPTH(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_cmd  (dec_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_cmd  (q_cmd)
   );

   assign req_ready = !q_full;
endmodule

// File: rtl/fsg_core.sv
// fsg_core: back end. Executes queued commands on channel state, runs the frame
// sequencer and timer catch-up, mixes and holds the result. Depends on fsg_pkg, fsg_ram.
module fsg_core import fsg_pkg::*; #(
   parameter int SEQ_PERIOD = SeqPeriodDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int SeqW = $clog2(SEQ_PERIOD);

   typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SUB, ST_CATCH, ST_WAIT, ST_MIX} state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic              power_ff, power_in;
   logic [SeqW-1:0]   seq_cnt_ff, seq_cnt_in;
   logic [2:0]        seq_step_ff, seq_step_in;
   logic [3:0]        en_ff, en_in, dac_ff, dac_in, len_en_ff, len_en_in;
   logic [8:0]        len_ff [4];
   logic [8:0]        len_in [4];
   logic signed [21:0] timer_ff [4];
   logic signed [21:0] timer_in [4];
   logic [10:0]       freq_ff [3];
   logic [10:0]       freq_in [3];
   logic [3:0]        vol_ff [3];
   logic [3:0]        vol_in [3];
   logic [3:0]        estart_ff [3];
   logic [3:0]        estart_in [3];
   logic [2:0]        eup_ff, eup_in;
   logic [2:0]        eper_ff [3];
   logic [2:0]        eper_in [3];
   logic [2:0]        etmr_ff [3];
   logic [2:0]        etmr_in [3];
   logic [1:0]        duty_ff [2];
   logic [1:0]        duty_in [2];
   logic [2:0]        dpos_ff [2];
   logic [2:0]        dpos_in [2];
   logic [6:0]        sweep_bits_ff, sweep_bits_in;
   logic [11:0]       shadow_ff, shadow_in;
   logic [3:0]        sweep_tmr_ff, sweep_tmr_in;
   logic              sweep_on_ff, sweep_on_in;
   logic [4:0]        wpos_ff, wpos_in;
   logic [1:0]        wlvl_ff, wlvl_in;
   logic [7:0]        nctrl_ff, nctrl_in;
   logic [14:0]       lfsr_ff, lfsr_in;
   logic [7:0]        pan_ff, pan_in;
   logic [5:0]        mvol_ff, mvol_in;

   // wave RAM: valid bits stand in for the power-up contents (byte i = i * 0x11)
   logic [WaveBytes-1:0] wvalid_ff, wvalid_in;
   logic                 ram_we;
   logic [7:0]           ram_a, ram_b;
   logic                 va_ff, vb_ff;
   logic [WaveAw-1:0]    aa_ff, ab_ff;
   logic [7:0]           wave_a, wave_b;

   logic [20:0] per_ch [4];

   function automatic logic [11:0] sweep_calc(input logic [11:0] sh, input logic [6:0] bits);
      logic [11:0] d;
      d = sh >> bits[2:0];
      return bits[3] ? sh - d : sh + d;
   endfunction

   function automatic logic [20:0] tone_period(input logic [10:0] f, input logic is_wave);
      logic [11:0] d;
      d = 12'd2048 - {1'b0, f};
      return is_wave ? {8'b0, d, 1'b0} : {7'b0, d, 2'b0};
   endfunction

   function automatic logic [20:0] noise_period(input logic [7:0] ctrl);
      return {15'b0, noise_div(ctrl[2:0])} << ctrl[7:4];
   endfunction

   function automatic logic [14:0] lfsr_step(input logic [14:0] l, input logic narrow);
      logic        b;
      logic [14:0] n;
      b = l[0] ^ l[1];
      n = {b, l[14:1]};
      if (narrow) begin
         n[6] = b;
      end
      return n;
   endfunction

   assign per_ch[0] = tone_period(freq_ff[0], 1'b0);
   assign per_ch[1] = tone_period(freq_ff[1], 1'b0);
   assign per_ch[2] = tone_period(freq_ff[2], 1'b1);
   assign per_ch[3] = noise_period(nctrl_ff);

   fsg_ram #(.WIDTH(8), .DEPTH(WaveBytes)) u_wave (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (cmd_ff.wave_idx),
      .wr_data   (cmd_ff.data),
      .rd_addr_a (cmd_ff.wave_idx),
      .rd_data_a (ram_a),
      .rd_addr_b (wpos_ff[4:1]),
      .rd_data_b (ram_b)
   );

   assign wave_a = va_ff ? ram_a : {aa_ff, aa_ff};
   assign wave_b = vb_ff ? ram_b : {ab_ff, ab_ff};

   // mix
   logic signed [8:0]  ch_out [4];
   logic signed [8:0]  sum_l, sum_r;
   logic signed [6:0]  wdiff;
   logic [3:0]         wsamp;
   logic signed [4:0]  gain_l, gain_r;
   logic signed [13:0] prod_l, prod_r;
   logic [7:0]         rd_byte;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         if (en_ff[c] && dac_ff[c]) begin
            ch_out[c] = duty_bit(duty_ff[c], dpos_ff[c]) ? $signed({3'b0, vol_ff[c], 2'b0})
                                                        : -$signed({3'b0, vol_ff[c], 2'b0});
         end else begin
            ch_out[c] = '0;
         end
      end
      wsamp = wpos_ff[0] ? wave_b[3:0] : wave_b[7:4];
      wdiff = $signed({2'b0, wsamp, 1'b0}) - 7'sd15;
      if (en_ff[2] && dac_ff[2]) begin
         case (wlvl_ff)
            2'd1:    ch_out[2] = 9'(wdiff <<< 2);
            2'd2:    ch_out[2] = 9'(wdiff <<< 1);
            2'd3:    ch_out[2] = 9'(wdiff);
            default: ch_out[2] = '0;
         endcase
      end else begin
         ch_out[2] = '0;
      end
      if (en_ff[3] && dac_ff[3]) begin
         ch_out[3] = lfsr_ff[0] ? -$signed({3'b0, vol_ff[2], 2'b0})
                                : $signed({3'b0, vol_ff[2], 2'b0});
      end else begin
         ch_out[3] = '0;
      end
      sum_l = '0;
      sum_r = '0;
      for (int c = 0; c < 4; c++) begin
         if (pan_ff[4 + c]) sum_l = sum_l + ch_out[c];
         if (pan_ff[c])     sum_r = sum_r + ch_out[c];
      end
      gain_l = $signed({1'b0, 4'({1'b0, mvol_ff[5:3]} + 4'd1)});
      gain_r = $signed({1'b0, 4'({1'b0, mvol_ff[2:0]} + 4'd1)});
      prod_l = sum_l * gain_l;
      prod_r = sum_r * gain_r;
   end

   // register read data
   always_comb begin
      unique case (cmd_ff.sel)
         R_SWEEP: rd_byte = {1'b1, sweep_bits_ff};
         R_LD1:   rd_byte = {duty_ff[0], 6'h3F};
         R_ENV1:  rd_byte = {estart_ff[0], eup_ff[0], eper_ff[0]};
         R_FHI1:  rd_byte = {1'b1, len_en_ff[0], 6'h3F};
         R_LD2:   rd_byte = {duty_ff[1], 6'h3F};
         R_ENV2:  rd_byte = {estart_ff[1], eup_ff[1], eper_ff[1]};
         R_FHI2:  rd_byte = {1'b1, len_en_ff[1], 6'h3F};
         R_DAC3:  rd_byte = {dac_ff[2], 7'h7F};
         R_LVL3:  rd_byte = {1'b1, wlvl_ff, 5'h1F};
         R_FHI3:  rd_byte = {1'b1, len_en_ff[2], 6'h3F};
         R_ENV4:  rd_byte = {estart_ff[2], eup_ff[2], eper_ff[2]};
         R_POLY4: rd_byte = nctrl_ff;
         R_FHI4:  rd_byte = {1'b1, len_en_ff[3], 6'h3F};
         R_MVOL:  rd_byte = {1'b0, mvol_ff[5:3], 1'b0, mvol_ff[2:0]};
         R_PAN:   rd_byte = pan_ff;
         R_POWER: rd_byte = {power_ff, 3'b111, en_ff};
         R_WAVE:  rd_byte = wave_a;
         default: rd_byte = 8'hFF;
      endcase
   end

   // next state
   always_comb begin
      logic [SeqW:0] seq_sum;
      logic          seq_fire;
      logic [2:0]    sw_per, tp;
      logic [11:0]   sw_n, sw_n2;
      logic [2:0]    et;
      logic          do_trig;
      logic [1:0]    trig_c;
      logic [7:0]    v;
      logic [3:0]    expired;

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      power_in      = power_ff;
      seq_cnt_in    = seq_cnt_ff;
      seq_step_in   = seq_step_ff;
      en_in         = en_ff;
      dac_in        = dac_ff;
      len_en_in     = len_en_ff;
      len_in        = len_ff;
      timer_in      = timer_ff;
      freq_in       = freq_ff;
      vol_in        = vol_ff;
      estart_in     = estart_ff;
      eup_in        = eup_ff;
      eper_in       = eper_ff;
      etmr_in       = etmr_ff;
      duty_in       = duty_ff;
      dpos_in       = dpos_ff;
      sweep_bits_in = sweep_bits_ff;
      shadow_in     = shadow_ff;
      sweep_tmr_in  = sweep_tmr_ff;
      sweep_on_in   = sweep_on_ff;
      wpos_in       = wpos_ff;
      wlvl_in       = wlvl_ff;
      nctrl_in      = nctrl_ff;
      lfsr_in       = lfsr_ff;
      pan_in        = pan_ff;
      mvol_in       = mvol_ff;
      wvalid_in     = wvalid_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      seq_sum       = '0;
      seq_fire      = 1'b0;
      sw_per        = '0;
      tp            = '0;
      sw_n          = '0;
      sw_n2         = '0;
      et            = '0;
      do_trig       = 1'b0;
      trig_c        = '0;
      v             = cmd_ff.data;
      expired       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_WAIT;
            case (cmd_ff.kind)
               CMD_TICK: begin
                  if (power_ff) begin
                     state_in = ST_SUB;
                     seq_sum = {1'b0, seq_cnt_ff} + (SeqW + 1)'(cmd_ff.cycles);
                     if (seq_sum >= (SeqW + 1)'(SEQ_PERIOD)) begin
                        seq_sum  = seq_sum - (SeqW + 1)'(SEQ_PERIOD);
                        seq_fire = 1'b1;
                     end
                     seq_cnt_in = seq_sum[SeqW-1:0];
                     if (seq_fire) begin
                        // length on even steps
                        if (!seq_step_ff[0]) begin
                           for (int c = 0; c < 4; c++) begin
                              if (len_en_ff[c] && len_ff[c] != '0) begin
                                 len_in[c] = len_ff[c] - 1'b1;
                                 if (len_ff[c] == 9'd1) en_in[c] = 1'b0;
                              end
                           end
                        end
                        // sweep on steps 2 and 6
                        if (seq_step_ff == 3'd2 || seq_step_ff == 3'd6) begin
                           sw_per = sweep_bits_ff[6:4];
                           if (sweep_tmr_in != '0) sweep_tmr_in = sweep_tmr_in - 1'b1;
                           if (sweep_tmr_in == '0) begin
                              sweep_tmr_in = (sw_per != '0) ? {1'b0, sw_per} : 4'd8;
                              if (sweep_on_ff && sw_per != '0) begin
                                 sw_n = sweep_calc(shadow_ff, sweep_bits_ff);
                                 if (sw_n[11]) begin
                                    en_in[0] = 1'b0;
                                 end else if (sweep_bits_ff[2:0] != '0) begin
                                    freq_in[0] = sw_n[10:0];
                                    shadow_in  = sw_n;
                                    sw_n2 = sweep_calc(sw_n, sweep_bits_ff);
                                    if (sw_n2[11]) en_in[0] = 1'b0;
                                 end
                              end
                           end
                        end
                        // envelope on step 7
                        if (seq_step_ff == 3'd7) begin
                           for (int e = 0; e < 3; e++) begin
                              if (eper_ff[e] != '0) begin
                                 et = etmr_ff[e];
                                 if (et != '0) et = et - 1'b1;
                                 if (et == '0) begin
                                    et = eper_ff[e];
                                    if (eup_ff[e] && vol_ff[e] != 4'd15) begin
                                       vol_in[e] = vol_ff[e] + 1'b1;
                                    end else if (!eup_ff[e] && vol_ff[e] != 4'd0) begin
                                       vol_in[e] = vol_ff[e] - 1'b1;
                                    end
                                 end
                                 etmr_in[e] = et;
                              end
                           end
                        end
                        seq_step_in = seq_step_ff + 1'b1;
                     end
                  end
               end

               CMD_WRITE: begin
                  if (power_ff || cmd_ff.sel == R_POWER) begin
                     unique case (cmd_ff.sel)
                        R_SWEEP: sweep_bits_in = v[6:0];
                        R_LD1: begin
                           duty_in[0] = v[7:6];
                           len_in[0]  = 9'd64 - {3'b0, v[5:0]};
                        end
                        R_ENV1, R_ENV2, R_ENV4: begin
                           tp = (cmd_ff.sel == R_ENV1) ? 3'd0 :
                                (cmd_ff.sel == R_ENV2) ? 3'd1 : 3'd2;
                           estart_in[tp[1:0]] = v[7:4];
                           eup_in[tp[1:0]]    = v[3];
                           eper_in[tp[1:0]]   = v[2:0];
                           trig_c = (cmd_ff.sel == R_ENV4) ? 2'd3 : tp[1:0];
                           dac_in[trig_c] = (v[7:3] != '0);
                           if (v[7:3] == '0) en_in[trig_c] = 1'b0;
                           trig_c = '0;
                        end
                        R_FLO1: freq_in[0][7:0] = v;
                        R_FLO2: freq_in[1][7:0] = v;
                        R_FLO3: freq_in[2][7:0] = v;
                        R_FHI1, R_FHI2, R_FHI3, R_FHI4: begin
                           trig_c = (cmd_ff.sel == R_FHI1) ? 2'd0 :
                                    (cmd_ff.sel == R_FHI2) ? 2'd1 :
                                    (cmd_ff.sel == R_FHI3) ? 2'd2 : 2'd3;
                           if (trig_c != 2'd3) freq_in[trig_c][10:8] = v[2:0];
                           len_en_in[trig_c] = v[6];
                           do_trig = v[7];
                        end
                        R_LD2: begin
                           duty_in[1] = v[7:6];
                           len_in[1]  = 9'd64 - {3'b0, v[5:0]};
                        end
                        R_DAC3: begin
                           dac_in[2] = v[7];
                           if (!v[7]) en_in[2] = 1'b0;
                        end
                        R_LEN3:  len_in[2] = 9'd256 - {1'b0, v};
                        R_LVL3:  wlvl_in = v[6:5];
                        R_LEN4:  len_in[3] = 9'd64 - {3'b0, v[5:0]};
                        R_POLY4: nctrl_in = v;
                        R_MVOL:  mvol_in = {v[6:4], v[2:0]};
                        R_PAN:   pan_in = v;
                        R_POWER: begin
                           if (!v[7]) begin
                              // power off: everything but wave RAM and sequencer
                              en_in = '0; dac_in = '0; len_en_in = '0; eup_in = '0;
                              for (int c = 0; c < 4; c++) begin
                                 len_in[c]   = '0;
                                 timer_in[c] = '0;
                              end
                              for (int e = 0; e < 3; e++) begin
                                 freq_in[e] = '0; vol_in[e] = '0; estart_in[e] = '0;
                                 eper_in[e] = '0; etmr_in[e] = '0;
                              end
                              for (int c = 0; c < 2; c++) begin
                                 duty_in[c] = '0;
                                 dpos_in[c] = '0;
                              end
                              sweep_bits_in = '0; shadow_in = '0; sweep_tmr_in = '0;
                              sweep_on_in = 1'b0; wpos_in = '0; wlvl_in = '0;
                              nctrl_in = '0; lfsr_in = '0; pan_in = '0; mvol_in = '0;
                              power_in = 1'b0;
                           end else if (!power_ff) begin
                              power_in    = 1'b1;
                              seq_step_in = '0;
                           end
                        end
                        R_WAVE: begin
                           ram_we = 1'b1;
                           wvalid_in[cmd_ff.wave_idx] = 1'b1;
                        end
                        default: ;
                     endcase

                     if (do_trig) begin
                        en_in[trig_c] = dac_in[trig_c];
                        if (len_in[trig_c] == '0) begin
                           len_in[trig_c] = (trig_c == 2'd2) ? 9'd256 : 9'd64;
                        end
                        case (trig_c)
                           2'd0, 2'd1: begin
                              timer_in[trig_c] =
                                 $signed({1'b0, tone_period(freq_in[trig_c], 1'b0)});
                              vol_in[trig_c]  = estart_in[trig_c];
                              etmr_in[trig_c] = eper_in[trig_c];
                           end
                           2'd2: begin
                              timer_in[2] = $signed({1'b0, tone_period(freq_in[2], 1'b1)});
                              wpos_in     = '0;
                           end
                           default: begin
                              timer_in[3] = $signed({1'b0, noise_period(nctrl_in)});
                              vol_in[2]   = estart_in[2];
                              etmr_in[2]  = eper_in[2];
                              lfsr_in     = 15'h7FFF;
                           end
                        endcase
                        if (trig_c == 2'd0) begin
                           sw_per       = sweep_bits_in[6:4];
                           shadow_in    = {1'b0, freq_in[0]};
                           sweep_tmr_in = (sw_per != '0) ? {1'b0, sw_per} : 4'd8;
                           sweep_on_in  = (sw_per != '0) || (sweep_bits_in[2:0] != '0);
                           if (sweep_bits_in[2:0] != '0) begin
                              sw_n = sweep_calc({1'b0, freq_in[0]}, sweep_bits_in);
                              if (sw_n[11]) en_in[0] = 1'b0;
                           end
                        end
                     end
                  end
               end

               default: ;
            endcase
         end

         ST_SUB: begin
            for (int c = 0; c < 4; c++) begin
               if (en_ff[c]) timer_in[c] = timer_ff[c] - $signed({16'b0, cmd_ff.cycles});
            end
            state_in = ST_CATCH;
         end

         // one missed period per cycle on every channel still behind
         ST_CATCH: begin
            for (int c = 0; c < 4; c++) begin
               expired[c] = en_ff[c] && (timer_ff[c][21] || timer_ff[c] == '0);
            end
            if (expired == '0) begin
               state_in = ST_WAIT;
            end else begin
               for (int c = 0; c < 4; c++) begin
                  if (expired[c]) timer_in[c] = timer_ff[c] + $signed({1'b0, per_ch[c]});
               end
               if (expired[0]) dpos_in[0] = dpos_ff[0] + 1'b1;
               if (expired[1]) dpos_in[1] = dpos_ff[1] + 1'b1;
               if (expired[2]) wpos_in = wpos_ff + 1'b1;
               if (expired[3]) lfsr_in = lfsr_step(lfsr_ff, nctrl_ff[3]);
            end
         end

         ST_WAIT: state_in = ST_MIX;

         ST_MIX: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.read_byte      = (cmd_ff.kind == CMD_READ) ? rd_byte : 8'h00;
               rsp_data_in.left_level     = prod_l[11:0];
               rsp_data_in.right_level    = prod_r[11:0];
               rsp_data_in.channel_active = en_ff;
               state_in                   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
      va_ff       <= wvalid_ff[cmd_ff.wave_idx];
      vb_ff       <= wvalid_ff[wpos_ff[4:1]];
      aa_ff       <= cmd_ff.wave_idx;
      ab_ff       <= wpos_ff[4:1];
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         power_ff      <= 1'b0;
         seq_cnt_ff    <= '0;
         seq_step_ff   <= '0;
         en_ff         <= '0;
         dac_ff        <= '0;
         len_en_ff     <= '0;
         eup_ff        <= '0;
         for (int c = 0; c < 4; c++) begin
            len_ff[c]   <= '0;
            timer_ff[c] <= '0;
         end
         for (int e = 0; e < 3; e++) begin
            freq_ff[e]   <= '0;
            vol_ff[e]    <= '0;
            estart_ff[e] <= '0;
            eper_ff[e]   <= '0;
            etmr_ff[e]   <= '0;
         end
         for (int c = 0; c < 2; c++) begin
            duty_ff[c] <= '0;
            dpos_ff[c] <= '0;
         end
         sweep_bits_ff <= '0;
         shadow_ff     <= '0;
         sweep_tmr_ff  <= '0;
         sweep_on_ff   <= 1'b0;
         wpos_ff       <= '0;
         wlvl_ff       <= '0;
         nctrl_ff      <= '0;
         lfsr_ff       <= 15'h7FFF;
         pan_ff        <= '0;
         mvol_ff       <= '0;
         wvalid_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         power_ff      <= power_in;
         seq_cnt_ff    <= seq_cnt_in;
         seq_step_ff   <= seq_step_in;
         en_ff         <= en_in;
         dac_ff        <= dac_in;
         len_en_ff     <= len_en_in;
         eup_ff        <= eup_in;
         len_ff        <= len_in;
         timer_ff      <= timer_in;
         freq_ff       <= freq_in;
         vol_ff        <= vol_in;
         estart_ff     <= estart_in;
         eper_ff       <= eper_in;
         etmr_ff       <= etmr_in;
         duty_ff       <= duty_in;
         dpos_ff       <= dpos_in;
         sweep_bits_ff <= sweep_bits_in;
         shadow_ff     <= shadow_in;
         sweep_tmr_ff  <= sweep_tmr_in;
         sweep_on_ff   <= sweep_on_in;
         wpos_ff       <= wpos_in;
         wlvl_ff       <= wlvl_in;
         nctrl_ff      <= nctrl_in;
         lfsr_ff       <= lfsr_in;
         pan_ff        <= pan_in;
         mvol_ff       <= mvol_in;
         wvalid_ff     <= wvalid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// File: rtl/four_channel_sound_generator_unit.sv
// Four-channel sound generator top level: front decoder/queue plus back end.
// Depends on fsg_pkg, fsg_front, fsg_core.
//
// Usage: one request item per bus access or tick (opcode tick / write / read,
// register offset, write byte, tick cycles). Every request gives exactly one
// response item: read data (0 unless a read), left and right mix levels and the
// enabled flags of the four channels, all as they stand after the request.
// A write, read or other opcode, or a tick with power off, passes the back
// end's execute, wait and mix states; a tick with power on passes execute,
// subtract, then the catch-up state, which repeats while any channel still
// has a missed timer period, then wait and mix. The back end takes one
// command at a time and pops the next only when it is back in idle.
// A two-entry command queue sits between request port and back end, so
// requests are taken while a finished response waits in the output register.
// When the receiver stalls, the response holds and the back end waits in its
// mix state; the queue fills and req_ready drops.
// Reset: power off, all channel state zero, noise LFSR all ones, wave RAM
// reads as byte i = i * 0x11 until written; no clearing pass.
module four_channel_sound_generator_unit import fsg_pkg::*; #(
   parameter int SEQ_PERIOD = SeqPeriodDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   // front: decode and queue
   fsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_cmd     (q_cmd)
   );

   // back: execute, sequencer, catch-up, mix, output register
   fsg_core #(.SEQ_PERIOD(SEQ_PERIOD)) u_core (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

// File: rtl/fsg_checker.sv
// fsg_checker: port-level checks of the sound generator, bound to the top level.
// Depends on fsg_pkg.
module fsg_checker import fsg_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // no response pending straight after reset
   a_rsp_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // queue empty after reset, so requests are taken
   a_req_open: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request port closed after reset");

   // waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting request changed");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // mix stays within full scale
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.left_level) <= 12'sd1920 &&
                     $signed(rsp_data.left_level) >= -12'sd1920 &&
                     $signed(rsp_data.right_level) <= 12'sd1920 &&
                     $signed(rsp_data.right_level) >= -12'sd1920))
      else $error("mix level out of range");
endmodule

bind four_channel_sound_generator_unit fsg_checker u_fsg_checker (.*);
